>>> design/swad_pkg.sv
// Shared types and constants for the side wall alignment detector.
// Used by swad_cell, swad_judge and side_wall_alignment_detector.
package swad_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int CFG_BITS    = 12;
    localparam int CFG_IDX_BITS = 8;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CFG_BITS-1:0]    cfg_word_t;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_WALL_LEVEL  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_WALL_LEVEL = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_TOLERANCE = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STABILITY_LIMIT  = 8'd3;

    // Reset values of the registers
    localparam cfg_word_t RST_LEFT_WALL_LEVEL  = 12'd1000;
    localparam cfg_word_t RST_RIGHT_WALL_LEVEL = 12'd1000;
    localparam cfg_word_t RST_CENTER_TOLERANCE = 12'd100;
    localparam cfg_word_t RST_STABILITY_LIMIT  = 12'd20;

    // Seeds for the running min and max
    localparam sample_t SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam sample_t SAMPLE_MIN = '0;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic                   turning;
    } in_item_t;

    typedef struct packed {
        logic aligned;
        logic window_full;
        logic left_steady;
        logic right_steady;
    } out_item_t;

    typedef struct packed {
        cfg_word_t left_wall_level;
        cfg_word_t right_wall_level;
        cfg_word_t center_tolerance;
        cfg_word_t stability_limit;
    } cfg_t;

    // Running extremes that travel down the cell chain
    typedef struct packed {
        logic    vld;
        sample_t lmin;
        sample_t lmax;
        sample_t rmin;
        sample_t rmax;
    } token_t;

endpackage

>>> design/swad_cell.sv
// One window cell: holds a left and right sample and folds them into the
// passing min/max token. Depends on swad_pkg.
module swad_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  swad_pkg::sample_t left_in,
    input  swad_pkg::sample_t right_in,
    output swad_pkg::sample_t left_out,
    output swad_pkg::sample_t right_out,
    input  swad_pkg::token_t  tok_in,
    output swad_pkg::token_t  tok_out
);

    swad_pkg::sample_t left_reg;
    swad_pkg::sample_t right_reg;
    swad_pkg::token_t  tok_reg;
    swad_pkg::token_t  tok_next;

    // Shift the samples toward the end of the chain
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            left_reg  <= left_in;
            right_reg <= right_in;
        end
    end

    // Fold this cell's samples into the token
    always_comb
    begin
        tok_next      = tok_in;
        tok_next.lmin = (left_reg  < tok_in.lmin) ? left_reg  : tok_in.lmin;
        tok_next.lmax = (left_reg  > tok_in.lmax) ? left_reg  : tok_in.lmax;
        tok_next.rmin = (right_reg < tok_in.rmin) ? right_reg : tok_in.rmin;
        tok_next.rmax = (right_reg > tok_in.rmax) ? right_reg : tok_in.rmax;
    end

    // Hand the token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign left_out  = left_reg;
    assign right_out = right_reg;
    assign tok_out   = tok_reg;

endmodule

>>> design/swad_judge.sv
// Alignment decision from the current samples, window extremes and
// configuration. Depends on swad_pkg.
module swad_judge (
    input  swad_pkg::sample_t   left_sample,
    input  swad_pkg::sample_t   right_sample,
    input  logic                turning,
    input  logic                full,
    input  swad_pkg::token_t    stats,
    input  swad_pkg::cfg_t      cfg,
    output swad_pkg::out_item_t result
);

    swad_pkg::sample_t lspread;
    swad_pkg::sample_t rspread;
    swad_pkg::sample_t diff;
    logic              lsteady;
    logic              rsteady;
    logic              lwall;
    logic              rwall;

    // Spread of each side and the centering error
    assign lspread = stats.lmax - stats.lmin;
    assign rspread = stats.rmax - stats.rmin;
    assign diff    = (left_sample > right_sample) ? left_sample - right_sample
                                                  : right_sample - left_sample;

    assign lsteady = lspread < cfg.stability_limit;
    assign rsteady = rspread < cfg.stability_limit;
    assign lwall   = left_sample  > cfg.left_wall_level;
    assign rwall   = right_sample > cfg.right_wall_level;

    // Zero everything while turning or before the window holds a full set
    always_comb
    begin
        result = '0;
        if (!turning && full)
        begin
            result.window_full  = 1'b1;
            result.left_steady  = lsteady;
            result.right_steady = rsteady;
            priority if (lwall && rwall && lsteady && rsteady)
                result.aligned = diff < cfg.center_tolerance;
            else if (lwall && !rwall && lsteady)
                result.aligned = 1'b1;
            else if (rwall && !lwall && rsteady)
                result.aligned = 1'b1;
            else
                result.aligned = 1'b0;
        end
    end

endmodule

>>> design/side_wall_alignment_detector.sv
// Side wall alignment detector top level: configuration registers, fill
// count, cell chain, control sequencer and output register.
// Depends on swad_pkg, swad_cell and swad_judge.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  in      | input     | in_valid/in_stall  | in_item  (swad_pkg::in_item_t)
//  out     | output    | out_valid/out_stall| out_item (swad_pkg::out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item that sweeps the window passes through the sweep and done states
// before the next accept: the min/max token walks one cell per cycle down the
// chain. Turning items and items before the window is full go straight to done.
// Reset clears the fill count, the sequencer and the output valid; window
// samples are not reset. A stalled output holds the result; the next item
// can be accepted while it waits, and its result is held until out is free.
module side_wall_alignment_detector #(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  swad_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output swad_pkg::out_item_t                  out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swad_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [swad_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    state_t              state_reg;
    swad_pkg::cfg_t      cfg_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                start_reg;
    logic                out_valid_reg;
    swad_pkg::out_item_t out_reg;
    swad_pkg::out_item_t res_reg;
    swad_pkg::out_item_t judged;
    swad_pkg::in_item_t  item_reg;
    logic                full_reg;
    logic                accept;
    logic                shift_en;
    logic                out_free;
    swad_pkg::token_t    seed;
    swad_pkg::sample_t   left_chain  [WINDOW_DEPTH+1];
    swad_pkg::sample_t   right_chain [WINDOW_DEPTH+1];
    swad_pkg::token_t    tok_chain   [WINDOW_DEPTH+1];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign shift_en  = accept && !in_item.turning;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Write the configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_wall_level  <= swad_pkg::RST_LEFT_WALL_LEVEL;
            cfg_reg.right_wall_level <= swad_pkg::RST_RIGHT_WALL_LEVEL;
            cfg_reg.center_tolerance <= swad_pkg::RST_CENTER_TOLERANCE;
            cfg_reg.stability_limit  <= swad_pkg::RST_STABILITY_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                swad_pkg::CFG_LEFT_WALL_LEVEL:  cfg_reg.left_wall_level  <= cfg_data;
                swad_pkg::CFG_RIGHT_WALL_LEVEL: cfg_reg.right_wall_level <= cfg_data;
                swad_pkg::CFG_CENTER_TOLERANCE: cfg_reg.center_tolerance <= cfg_data;
                swad_pkg::CFG_STABILITY_LIMIT:  cfg_reg.stability_limit  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the fill count, saturating at a full window; a turning item clears it
    always_comb
    begin
        if (in_item.turning)
            fill_next = '0;
        else if (fill_reg == FILL_FULL)
            fill_next = fill_reg;
        else
            fill_next = fill_reg + FILL_W'(1);
    end

    // Cell chain: samples shift in at the head, token walks one cell a cycle
    assign left_chain[0]  = in_item.left_sample;
    assign right_chain[0] = in_item.right_sample;

    always_comb
    begin
        seed      = '0;
        seed.vld  = start_reg;
        seed.lmin = swad_pkg::SAMPLE_MAX;
        seed.lmax = swad_pkg::SAMPLE_MIN;
        seed.rmin = swad_pkg::SAMPLE_MAX;
        seed.rmax = swad_pkg::SAMPLE_MIN;
    end

    assign tok_chain[0] = seed;

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        swad_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .left_in   (left_chain[i]),
            .right_in  (right_chain[i]),
            .left_out  (left_chain[i+1]),
            .right_out (right_chain[i+1]),
            .tok_in    (tok_chain[i]),
            .tok_out   (tok_chain[i+1])
        );
    end

    swad_judge u_judge (
        .left_sample  (item_reg.left_sample),
        .right_sample (item_reg.right_sample),
        .turning      (item_reg.turning),
        .full         (full_reg),
        .stats        (tok_chain[WINDOW_DEPTH]),
        .cfg          (cfg_reg),
        .result       (judged)
    );

    // Hold the accepted item for the decision
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
            full_reg <= (fill_next == FILL_FULL);
        end
    end

    // Sequencer, fill count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        fill_reg <= fill_next;
                        if (!in_item.turning && fill_next == FILL_FULL)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= ST_SWEEP;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    if (tok_chain[WINDOW_DEPTH].vld)
                    begin
                        res_reg   <= judged;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg       <= full_reg && !item_reg.turning ? res_reg : judged;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // An accepted item blocks the input until its result is loaded into the output register
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after accept");

    // Aligned or steady only comes with a full window
    a_full_needed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.aligned || out_item.left_steady || out_item.right_steady)
        |-> out_item.window_full)
        else $error("result flags set without a full window");

    // Fill count never passes the window depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond window depth");

    // The token leaves the chain only during a sweep
    a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[WINDOW_DEPTH].vld |-> state_reg == ST_SWEEP)
        else $error("token left the chain outside a sweep");

endmodule
